### rtl/gld_pkg.sv
// gld_pkg: shared types and constants for the gaussian log density block
// no dependencies; imported by gaussian_log_density and tb_top
package gld_pkg;

   localparam int DEF_MAX_DIM = 8;

   // dimension register reset value
   localparam logic [3:0] DIM_RESET = 4'd8;

   // request type codes
   localparam logic [1:0] REQ_MATRIX = 2'd0;
   localparam logic [1:0] REQ_MEAN   = 2'd1;
   localparam logic [1:0] REQ_SAMPLE = 2'd2;

   // status codes
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_SINGULAR  = 2'd1;
   localparam logic [1:0] STAT_SATURATED = 2'd2;

   // ln2 in Q0.32, held as a positive 33 bit signed operand
   localparam logic signed [32:0] LN2_Q32 = 33'sh0B17217F8;

   // accumulator clamp, 2^46 + 1
   localparam logic signed [55:0] ACC_LIM = 56'sd70368744177665;

   // restoring divider steps, one quotient bit per cycle
   localparam int DIV_STEPS = 63;

   // log2 fraction bits, one squaring each
   localparam int LOG_FRAC = 16;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DREAD,
      ST_DWAIT,
      ST_LNORM,
      ST_LSQ,
      ST_LCHK,
      ST_LMUL,
      ST_LACC,
      ST_BREAD,
      ST_BINIT,
      ST_PREAD,
      ST_PMUL,
      ST_PACC,
      ST_DIVSET,
      ST_DIV,
      ST_DIVEND,
      ST_N2,
      ST_FIN
   } state_type;

endpackage

### rtl/gld_ram.sv
// gld_ram: generic single write, single read ram with registered read data
// no dependencies
module gld_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/gaussian_log_density.sv
// gaussian_log_density: multivariate gaussian log density from a square-root covariance
// depends on gld_pkg and gld_ram
//
//  channel   ports                                   handshake
//  request   req_type req_row_index req_col_index    start & !busy
//            req_value req_last
//  response  rsp_log_density rsp_status              rsp_strobe, one cycle
//  csr       csr_dimension                           csr_valid & csr_ready
//
// load transactions (matrix, mean, sample) are written only while the block is idle
// a sample transaction with last set starts the solve; busy stays high until the solve ends,
//   its length set by the 63 step bit-serial divider per row and the log unit
//   (up to 31 normalize steps, 16 squarings) per diagonal
// a zero diagonal ends the solve early with the singular status
// reset is synchronous; the stores are undefined until written
// the response strobe cannot be stalled
module gaussian_log_density import gld_pkg::*; #(
   parameter int MAX_DIM = DEF_MAX_DIM
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [2:0]  req_row_index,
   input  logic [2:0]  req_col_index,
   input  logic [31:0] req_value,
   input  logic        req_last,
   output logic        rsp_strobe,
   output logic [31:0] rsp_log_density,
   output logic [1:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_dimension
);

   localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int CNT_W  = $clog2(MAX_DIM + 1);
   localparam int MDEPTH = MAX_DIM * MAX_DIM;
   localparam int MADR_W = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;

   state_type state_ff, state_in;
   logic [3:0]       dim_ff;
   logic [CNT_W-1:0] n_cnt;
   logic [CNT_W-1:0] i_ff, i_in, j_ff, j_in;

   // ram ports
   logic              mat_we, mean_we, work_we;
   logic [MADR_W-1:0] mat_wr_addr, mat_rd_addr;
   logic [IDX_W-1:0]  mean_wr_addr, work_wr_addr, vec_rd_addr;
   logic [31:0]       work_wr_data;
   logic [31:0]       mat_rd_data, mean_rd_data, work_rd_data;

   // shared multiplier
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod_ff;

   // log unit
   logic [31:0] y_ff, y_in;
   logic [4:0]  p_ff, p_in;
   logic [3:0]  k_ff, k_in;
   logic [15:0] frac_ff, frac_in;
   logic        ln_neg_ff, ln_neg_in;
   logic signed [27:0] logdet_ff, logdet_in;
   logic [31:0] m_abs, sq_top;
   logic signed [21:0] l2_val;
   logic [21:0] l2_mag;
   logic signed [65:0] ln_rnd;
   logic signed [27:0] ln_val;

   // back-substitution and divider
   logic signed [55:0] acc_ff, acc_in, acc_cl, acc_sub;
   logic signed [65:0] prod_adj, prod_q;
   logic [46:0] acc_mag;
   logic [31:0] diag_ff, diag_in, dmag_ff, dmag_in, rem_ff, rem_in;
   logic [62:0] dq_ff, dq_in;
   logic [5:0]  step_ff, step_in;
   logic        neg_ff, neg_in;
   logic [32:0] div_trial, div_diff;
   logic        div_ge;
   logic [31:0] z_val;
   logic        z_sat;
   logic [51:0] n2_ff, n2_in;
   logic        sat_ff, sat_in;
   logic signed [55:0] res_full;
   logic [31:0] res_val;
   logic        res_sat;

   // response registers
   logic        rsp_strobe_ff, rsp_strobe_in;
   logic [31:0] rsp_log_ff, rsp_log_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   // request decode
   logic accept, row_ok, col_ok, go;

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = ~busy;
   assign accept    = start & ~busy;
   assign row_ok    = int'(req_row_index) < MAX_DIM;
   assign col_ok    = int'(req_col_index) < MAX_DIM;
   assign go        = accept && (req_type == REQ_SAMPLE) && row_ok && req_last;

   // effective dimension
   always_comb begin
      if (dim_ff == 4'd0) begin
         n_cnt = CNT_W'(1);
      end else if (int'(dim_ff) > MAX_DIM) begin
         n_cnt = CNT_W'(MAX_DIM);
      end else begin
         n_cnt = CNT_W'(dim_ff);
      end
   end

   // stores
   gld_ram #(.WIDTH(32), .DEPTH(MDEPTH)) u_matrix (
      .clock   (clock),
      .wr_en   (mat_we),
      .wr_addr (mat_wr_addr),
      .wr_data (req_value),
      .rd_addr (mat_rd_addr),
      .rd_data (mat_rd_data)
   );

   gld_ram #(.WIDTH(32), .DEPTH(MAX_DIM)) u_mean (
      .clock   (clock),
      .wr_en   (mean_we),
      .wr_addr (mean_wr_addr),
      .wr_data (req_value),
      .rd_addr (vec_rd_addr),
      .rd_data (mean_rd_data)
   );

   gld_ram #(.WIDTH(32), .DEPTH(MAX_DIM)) u_work (
      .clock   (clock),
      .wr_en   (work_we),
      .wr_addr (work_wr_addr),
      .wr_data (work_wr_data),
      .rd_addr (vec_rd_addr),
      .rd_data (work_rd_data)
   );

   // log datapath
   assign m_abs  = mat_rd_data[31] ? (~mat_rd_data + 32'd1) : mat_rd_data;
   assign sq_top = prod_ff[61:30];
   assign l2_val = $signed({6'({1'b0, p_ff}) - 6'd16, frac_ff});
   assign l2_mag = l2_val[21] ? (~l2_val + 22'd1) : l2_val;
   assign ln_rnd = prod_ff + 66'sh80000000;
   assign ln_val = ln_neg_ff ? -$signed({6'd0, ln_rnd[53:32]})
                             : $signed({6'd0, ln_rnd[53:32]});

   // product scaled by 2^-16, truncated toward zero
   assign prod_adj = prod_ff + (prod_ff[65] ? 66'sd65535 : 66'sd0);
   assign prod_q   = prod_adj >>> 16;
   assign acc_sub  = acc_ff - prod_q[55:0];

   // clamp and magnitude for the divider
   always_comb begin
      if (acc_ff > ACC_LIM) begin
         acc_cl = ACC_LIM;
      end else if (acc_ff < -ACC_LIM) begin
         acc_cl = -ACC_LIM;
      end else begin
         acc_cl = acc_ff;
      end
   end
   assign acc_mag = acc_cl[55] ? 47'(-acc_cl) : acc_cl[46:0];

   // restoring divider step
   assign div_trial = {rem_ff, dq_ff[62]};
   assign div_ge    = div_trial >= {1'b0, dmag_ff};
   assign div_diff  = div_trial - {1'b0, dmag_ff};

   // quotient sign and saturation
   always_comb begin
      z_sat = 1'b0;
      if (neg_ff) begin
         if (dq_ff > 63'h80000000) begin
            z_val = 32'h80000000;
            z_sat = 1'b1;
         end else begin
            z_val = ~dq_ff[31:0] + 32'd1;
         end
      end else begin
         if (dq_ff > 63'h7FFFFFFF) begin
            z_val = 32'h7FFFFFFF;
            z_sat = 1'b1;
         end else begin
            z_val = dq_ff[31:0];
         end
      end
   end

   // final result with saturation
   assign res_full = -$signed({{28{logdet_ff[27]}}, logdet_ff})
                     - $signed({5'd0, n2_ff[51:1]});
   always_comb begin
      res_sat = 1'b0;
      if (res_full > 56'sd2147483647) begin
         res_val = 32'h7FFFFFFF;
         res_sat = 1'b1;
      end else if (res_full < -56'sd2147483648) begin
         res_val = 32'h80000000;
         res_sat = 1'b1;
      end else begin
         res_val = res_full[31:0];
      end
   end

   // sequencer: next state, ram control, datapath registers
   always_comb begin
      state_in      = state_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      y_in          = y_ff;
      p_in          = p_ff;
      k_in          = k_ff;
      frac_in       = frac_ff;
      ln_neg_in     = ln_neg_ff;
      logdet_in     = logdet_ff;
      acc_in        = acc_ff;
      diag_in       = diag_ff;
      dmag_in       = dmag_ff;
      rem_in        = rem_ff;
      dq_in         = dq_ff;
      step_in       = step_ff;
      neg_in        = neg_ff;
      n2_in         = n2_ff;
      sat_in        = sat_ff;
      rsp_strobe_in = 1'b0;
      rsp_log_in    = rsp_log_ff;
      rsp_status_in = rsp_status_ff;
      mul_a         = '0;
      mul_b         = '0;
      mat_we        = 1'b0;
      mean_we       = 1'b0;
      work_we       = 1'b0;
      mat_wr_addr   = MADR_W'(int'(req_row_index) * MAX_DIM + int'(req_col_index));
      mean_wr_addr  = IDX_W'(req_row_index);
      work_wr_addr  = IDX_W'(req_row_index);
      work_wr_data  = req_value;
      mat_rd_addr   = MADR_W'(int'(i_ff) * (MAX_DIM + 1));
      vec_rd_addr   = IDX_W'(i_ff);

      case (state_ff)
         ST_IDLE: begin
            // load transactions
            mat_we  = accept && (req_type == REQ_MATRIX) && row_ok && col_ok;
            mean_we = accept && (req_type == REQ_MEAN) && row_ok;
            work_we = accept && (req_type == REQ_SAMPLE) && row_ok;
            if (go) begin
               i_in      = '0;
               logdet_in = '0;
               n2_in     = '0;
               sat_in    = 1'b0;
               state_in  = ST_DREAD;
            end
         end
         ST_DREAD: begin
            state_in = ST_DWAIT;
         end
         ST_DWAIT: begin
            // singular check, then start the log of |diag|
            if (mat_rd_data == 32'd0) begin
               rsp_strobe_in = 1'b1;
               rsp_log_in    = 32'd0;
               rsp_status_in = STAT_SINGULAR;
               state_in      = ST_IDLE;
            end else begin
               frac_in = '0;
               k_in    = 4'(LOG_FRAC - 1);
               if (m_abs[31]) begin
                  y_in     = {1'b0, m_abs[31:1]};
                  p_in     = 5'd31;
                  state_in = ST_LSQ;
               end else begin
                  y_in     = m_abs;
                  p_in     = 5'd30;
                  state_in = ST_LNORM;
               end
            end
         end
         ST_LNORM: begin
            // one bit of leading-one search per cycle
            if (y_ff[30]) begin
               state_in = ST_LSQ;
            end else begin
               y_in = {y_ff[30:0], 1'b0};
               p_in = p_ff - 5'd1;
            end
         end
         ST_LSQ: begin
            mul_a    = $signed({2'b00, y_ff[30:0]});
            mul_b    = $signed({2'b00, y_ff[30:0]});
            state_in = ST_LCHK;
         end
         ST_LCHK: begin
            if (sq_top[31]) begin
               frac_in[k_ff] = 1'b1;
               y_in          = {1'b0, sq_top[31:1]};
            end else begin
               y_in = sq_top;
            end
            if (k_ff == 4'd0) begin
               state_in = ST_LMUL;
            end else begin
               k_in     = k_ff - 4'd1;
               state_in = ST_LSQ;
            end
         end
         ST_LMUL: begin
            mul_a     = $signed({11'd0, l2_mag});
            mul_b     = LN2_Q32;
            ln_neg_in = l2_val[21];
            state_in  = ST_LACC;
         end
         ST_LACC: begin
            logdet_in = logdet_ff + ln_val;
            if (i_ff == n_cnt - CNT_W'(1)) begin
               state_in = ST_BREAD;
            end else begin
               i_in     = i_ff + CNT_W'(1);
               state_in = ST_DREAD;
            end
         end
         ST_BREAD: begin
            state_in = ST_BINIT;
         end
         ST_BINIT: begin
            // d_i = x_i - mean_i
            acc_in  = $signed({{24{work_rd_data[31]}}, work_rd_data})
                      - $signed({{24{mean_rd_data[31]}}, mean_rd_data});
            diag_in = mat_rd_data;
            j_in    = i_ff + CNT_W'(1);
            if (i_ff + CNT_W'(1) < n_cnt) begin
               state_in = ST_PREAD;
            end else begin
               state_in = ST_DIVSET;
            end
         end
         ST_PREAD: begin
            mat_rd_addr = MADR_W'(int'(i_ff) * MAX_DIM + int'(j_ff));
            vec_rd_addr = IDX_W'(j_ff);
            state_in    = ST_PMUL;
         end
         ST_PMUL: begin
            mul_a    = $signed({mat_rd_data[31], mat_rd_data});
            mul_b    = $signed({work_rd_data[31], work_rd_data});
            state_in = ST_PACC;
         end
         ST_PACC: begin
            acc_in = acc_sub;
            j_in   = j_ff + CNT_W'(1);
            if (j_ff + CNT_W'(1) < n_cnt) begin
               state_in = ST_PREAD;
            end else begin
               state_in = ST_DIVSET;
            end
         end
         ST_DIVSET: begin
            dq_in    = {acc_mag, 16'd0};
            rem_in   = '0;
            dmag_in  = diag_ff[31] ? (~diag_ff + 32'd1) : diag_ff;
            neg_in   = acc_cl[55] ^ diag_ff[31];
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = div_ge ? div_diff[31:0] : div_trial[31:0];
            dq_in  = {dq_ff[61:0], div_ge};
            if (step_ff == 6'(DIV_STEPS - 1)) begin
               state_in = ST_DIVEND;
            end else begin
               step_in = step_ff + 6'd1;
            end
         end
         ST_DIVEND: begin
            // store z_i and square it
            work_we      = 1'b1;
            work_wr_addr = IDX_W'(i_ff);
            work_wr_data = z_val;
            sat_in       = sat_ff | z_sat;
            mul_a        = $signed({z_val[31], z_val});
            mul_b        = $signed({z_val[31], z_val});
            state_in     = ST_N2;
         end
         ST_N2: begin
            n2_in = n2_ff + 52'(prod_ff[65:16]);
            if (i_ff == '0) begin
               state_in = ST_FIN;
            end else begin
               i_in     = i_ff - CNT_W'(1);
               state_in = ST_BREAD;
            end
         end
         ST_FIN: begin
            rsp_strobe_in = 1'b1;
            rsp_log_in    = res_val;
            rsp_status_in = (sat_ff | res_sat) ? STAT_SATURATED : STAT_OK;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         dim_ff        <= DIM_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_valid && csr_ready) begin
            dim_ff <= csr_dimension;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      prod_ff       <= mul_a * mul_b;
      i_ff          <= i_in;
      j_ff          <= j_in;
      y_ff          <= y_in;
      p_ff          <= p_in;
      k_ff          <= k_in;
      frac_ff       <= frac_in;
      ln_neg_ff     <= ln_neg_in;
      logdet_ff     <= logdet_in;
      acc_ff        <= acc_in;
      diag_ff       <= diag_in;
      dmag_ff       <= dmag_in;
      rem_ff        <= rem_in;
      dq_ff         <= dq_in;
      step_ff       <= step_in;
      neg_ff        <= neg_in;
      n2_ff         <= n2_in;
      sat_ff        <= sat_in;
      rsp_log_ff    <= rsp_log_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_log_density = rsp_log_ff;
   assign rsp_status      = rsp_status_ff;

   // a result comes only from a running solve, and one per solve
   a_strobe_from_solve: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff != ST_IDLE))
      else $error("response strobe without a running solve");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("response strobe held for more than one cycle");

   a_go_starts_solve: assert property (@(posedge clock) disable iff (reset)
      go |=> busy)
      else $error("last sample transaction did not start a solve");

   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_status_ff == STAT_SINGULAR) |-> rsp_log_ff == 32'd0)
      else $error("singular response with nonzero log density");

endmodule

### tb/tb_top.sv
// tb_top: self-checking testbench for gaussian_log_density
// depends on gld_pkg and the gaussian_log_density rtl; carries its own fixed point predictor
`timescale 1ns / 100ps

module tb_top;
   import gld_pkg::*;

   // request type with no meaning, ignored by the block
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   typedef struct {
      logic [31:0] density;
      logic [1:0]  status;
   } density_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_type = REQ_MATRIX;
   logic [2:0]  req_row_index = '0;
   logic [2:0]  req_col_index = '0;
   logic [31:0] req_value = '0;
   logic        req_last = 1'b0;
   logic        rsp_strobe;
   logic [31:0] rsp_log_density;
   logic [1:0]  rsp_status;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_dimension = '0;

   // predictor state
   longint   mat_q[64];
   longint   mean_q[8];
   longint   work_q[8];
   logic [3:0] dim_q;

   density_type expected_q[$];
   int       err_count = 0;
   bit       gaps_on = 1'b1;

   gaussian_log_density dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #20ms;
      $display("tb_top NOT OK");
      $finish;
   end

   task automatic report_mismatch(string what, longint exp_v, longint got_v);
      $display("mismatch %s: expected %0h got %0h at %0t", what, exp_v, got_v, $realtime);
      err_count++;
   endtask

   function automatic longint sat32(longint v, ref bit sat);
      if (v > 64'sd2147483647) begin
         sat = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         sat = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // ln(m / 2^16) in q16.16 via leading one plus 16 mantissa squarings
   function automatic longint ln_fixed(longint unsigned m);
      int p;
      longint unsigned y, mag, r;
      longint l2;
      p = 31;
      while (p > 0 && !m[p]) p--;
      if (p <= 30) y = m << (30 - p);
      else y = m >> (p - 30);
      l2 = longint'(p - 16) * 65536;
      for (int k = 15; k >= 0; k--) begin
         y = (y * y) >> 30;
         if (y >= 64'h8000_0000) begin
            l2 += longint'(1) << k;
            y >>= 1;
         end
      end
      mag = (l2 < 0) ? longint'(-l2) : longint'(l2);
      r = (mag * 64'd2977044472 + 64'h8000_0000) >> 32;
      return (l2 < 0) ? -longint'(r) : longint'(r);
   endfunction

   // back-substitution solve and log density, updates the work vector
   function automatic density_type solve_density();
      density_type d;
      int n;
      bit sat;
      longint logdet, n2, acc, diag, res;
      longint unsigned m;
      sat = 1'b0;
      logdet = 0;
      n2 = 0;
      n = (dim_q == 0) ? 1 : ((dim_q > 8) ? 8 : int'(dim_q));
      for (int i = 0; i < n; i++) begin
         if (mat_q[i*8+i] == 0) begin
            d.density = '0;
            d.status = STAT_SINGULAR;
            return d;
         end
      end
      for (int i = n - 1; i >= 0; i--) begin
         acc = work_q[i] - mean_q[i];
         diag = mat_q[i*8+i];
         for (int j = i + 1; j < n; j++)
            acc -= (mat_q[i*8+j] * work_q[j]) / 65536;
         if (acc > 64'sd70368744177665) acc = 64'sd70368744177665;
         if (acc < -64'sd70368744177665) acc = -64'sd70368744177665;
         work_q[i] = sat32((acc * 65536) / diag, sat);
      end
      for (int i = 0; i < n; i++) begin
         diag = mat_q[i*8+i];
         m = (diag < 0) ? longint'(-diag) : longint'(diag);
         logdet += ln_fixed(m);
         n2 += (work_q[i] * work_q[i]) / 65536;
      end
      res = sat32(-logdet - n2 / 2, sat);
      d.density = res[31:0];
      d.status = sat ? STAT_SATURATED : STAT_OK;
      return d;
   endfunction

   // apply one accepted transaction to the predictor
   task automatic predict_req(logic [1:0] t, logic [2:0] r, logic [2:0] c,
                              logic [31:0] v, logic l);
      longint sv;
      sv = longint'(signed'(v));
      case (t)
         REQ_MATRIX: mat_q[r*8+c] = sv;
         REQ_MEAN:   mean_q[r] = sv;
         REQ_SAMPLE: begin
            work_q[r] = sv;
            if (l) expected_q.push_back(solve_density());
         end
         default: ;
      endcase
   endtask

   task automatic send_req(logic [1:0] t, logic [2:0] r, logic [2:0] c,
                           logic [31:0] v, logic l);
      while (gaps_on && $urandom_range(99) < 21) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_type <= t;
      req_row_index <= r;
      req_col_index <= c;
      req_value <= v;
      req_last <= l;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_req(t, r, c, v, l);
   endtask

   // hold off until every expected result is in and the block is idle
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_dimension(logic [3:0] v);
      drain_results();
      csr_valid <= 1'b1;
      csr_dimension <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      dim_q = v;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] rand_value();
      int sel;
      sel = $urandom_range(99);
      if (sel < 60) return 32'(signed'($urandom_range(524288)) - 262144);
      if (sel < 85) return $urandom();
      if (sel < 92) return 32'h7fff_ffff;
      return 32'h8000_0000;
   endfunction

   function automatic logic [31:0] rand_diag();
      logic [31:0] mag;
      mag = 32'($urandom_range(262144, 16384));
      if ($urandom_range(9) == 0) mag = $urandom_range(255, 1);
      if ($urandom_range(19) == 0) mag = 32'h7fff_ffff;
      return $urandom_range(1) ? -mag : mag;
   endfunction

   // result checker
   always @(posedge clock) begin
      density_type e;
      if (!reset && rsp_strobe) begin
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected result", 0, rsp_log_density);
         end else begin
            e = expected_q.pop_front();
            if (rsp_log_density !== e.density)
               report_mismatch("log_density", e.density, rsp_log_density);
            if (rsp_status !== e.status)
               report_mismatch("status", e.status, rsp_status);
         end
      end
   end

   // every store entry gets written before any solve reads it
   task automatic test_load_all();
      for (int r = 0; r < 8; r++) begin
         for (int c = 0; c < 8; c++)
            send_req(REQ_MATRIX, 3'(r), 3'(c),
                     (r == c) ? 32'h0001_0000 : rand_value(), 1'b0);
         send_req(REQ_MEAN, 3'(r), 3'd0, 32'h0, 1'b0);
         send_req(REQ_SAMPLE, 3'(r), 3'd0, 32'h0, 1'b0);
      end
   endtask

   task automatic test_directed();
      send_req(REQ_SAMPLE, 3'd7, 3'd7, 32'h0001_0000, 1'b1);
      send_req(REQ_UNUSED, 3'd7, 3'd7, 32'hffff_ffff, 1'b1);
      send_req(REQ_MATRIX, 3'd0, 3'd0, 32'h0002_0000, 1'b1);
      send_req(REQ_MEAN, 3'd3, 3'd5, 32'h8000_0000, 1'b1);
      send_req(REQ_MATRIX, 3'd6, 3'd1, 32'h7fff_ffff, 1'b0);
      send_req(REQ_SAMPLE, 3'd0, 3'd7, 32'h0003_0000, 1'b1);
      // zero diagonal gives singular
      send_req(REQ_MATRIX, 3'd4, 3'd4, 32'h0, 1'b0);
      send_req(REQ_SAMPLE, 3'd2, 3'd0, 32'h0001_0000, 1'b1);
      send_req(REQ_MATRIX, 3'd4, 3'd4, 32'hffff_0000, 1'b0);
      // tiny diagonal with extreme sample saturates
      send_req(REQ_MATRIX, 3'd3, 3'd3, 32'h0000_0001, 1'b0);
      send_req(REQ_SAMPLE, 3'd3, 3'd0, 32'h7fff_ffff, 1'b0);
      send_req(REQ_MEAN, 3'd3, 3'd0, 32'h8000_0000, 1'b0);
      send_req(REQ_SAMPLE, 3'd5, 3'd0, 32'h8000_0000, 1'b1);
      send_req(REQ_MATRIX, 3'd3, 3'd3, 32'h8000_0000, 1'b0);
      send_req(REQ_MEAN, 3'd3, 3'd0, 32'h0, 1'b0);
      send_req(REQ_SAMPLE, 3'd1, 3'd0, 32'h7fff_ffff, 1'b1);
      send_req(REQ_MATRIX, 3'd3, 3'd3, 32'h7fff_ffff, 1'b0);
      send_req(REQ_SAMPLE, 3'd1, 3'd0, 32'h0000_0000, 1'b1);
   endtask

   task automatic test_dimensions();
      logic [3:0] dims[5] = '{4'd0, 4'd1, 4'd15, 4'd9, 4'd3};
      foreach (dims[k]) begin
         write_dimension(dims[k]);
         send_req(REQ_SAMPLE, 3'd0, 3'd0, rand_value(), 1'b1);
         send_req(REQ_SAMPLE, 3'd7, 3'd0, rand_value(), 1'b1);
      end
   endtask

   // one well-formed load-then-solve sequence with random content, or noise
   task automatic random_sequence(int n);
      int k, r, c;
      if ($urandom_range(99) < 20) begin
         send_req(2'($urandom()), 3'($urandom()), 3'($urandom()), rand_value(),
                  1'($urandom()));
         return;
      end
      k = $urandom_range(6);
      repeat (k) begin
         r = $urandom_range(n - 1);
         case ($urandom_range(3))
            0: begin
               c = $urandom_range(n - 1, r);
               send_req(REQ_MATRIX, 3'(r), 3'(c),
                        (r == c) ? rand_diag() : rand_value(), 1'b0);
            end
            1: send_req(REQ_MEAN, 3'(r), 3'($urandom()), rand_value(), 1'b0);
            2: send_req(REQ_SAMPLE, 3'(r), 3'($urandom()), rand_value(), 1'b0);
            default: send_req(REQ_MATRIX, 3'($urandom()), 3'($urandom()), rand_value(),
                              1'b0);
         endcase
      end
      send_req(REQ_SAMPLE, 3'($urandom_range(n - 1)), 3'($urandom()), rand_value(), 1'b1);
   endtask

   task automatic test_random();
      logic [3:0] dims[6] = '{4'd2, 4'd8, 4'd1, 4'd5, 4'd8, 4'd4};
      foreach (dims[k]) begin
         write_dimension(dims[k]);
         gaps_on = (k != 3);
         repeat (45) random_sequence((dims[k] > 8) ? 8 : int'(dims[k]));
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      int w;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      dim_q = DIM_RESET;
      @(posedge clock);
      test_load_all();
      test_directed();
      drain_results();
      test_dimensions();
      test_random();
      start <= 1'b0;
      w = 0;
      while (expected_q.size() != 0 && w < 200000) begin
         @(posedge clock);
         w++;
      end
      if (expected_q.size() != 0) begin
         $display("tb_top NOT OK");
         $finish;
      end else begin
         repeat (20) @(posedge clock);
         if (err_count == 0) begin
            $display("tb_top OK");
         end else begin
            $display("tb_top NOT OK");
         end
         $finish;
      end
   end

endmodule
